### src/salru_pkg.sv
// Package with the cache geometry, payload types and helper functions.
package salru_pkg;

    localparam int Ways        = 4;
    localparam int BlockBytes  = 32;
    localparam int CacheBytes  = 16384;
    localparam int AddressBits = 24;

    localparam int RawSets  = CacheBytes / (BlockBytes * Ways);
    localparam int NumSets  = (RawSets == 0) ? 1 : RawSets;
    localparam int OffBits  = $clog2(BlockBytes);
    localparam int IdxBits  = $clog2(NumSets);
    localparam int IdxW     = (IdxBits == 0) ? 1 : IdxBits;
    localparam int TagBits  = (AddressBits > OffBits + IdxBits) ?
                              (AddressBits - OffBits - IdxBits) : 0;
    localparam int TagW     = (TagBits == 0) ? 1 : TagBits;
    localparam int WayW     = (Ways <= 1) ? 1 : $clog2(Ways);
    localparam int RankW    = WayW;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [23:0] address;
    } salru_in_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] hit_way;
        logic       memory_read;
        logic       memory_write;
    } salru_out_t;

    typedef logic [TagW-1:0]             tag_t;
    typedef logic [IdxW-1:0]             set_t;
    typedef logic [Ways-1:0][TagW-1:0]   tag_row_t;
    typedef logic [Ways-1:0][RankW-1:0]  rank_row_t;

    // Classified access that the front hands to the back.
    typedef struct packed {
        logic is_write;
        set_t set;
        tag_t tag;
    } salru_req_t;

    function automatic set_t addr_set(input logic [23:0] a);
        logic [AddressBits-1:0] m;
        logic [IdxW-1:0] s;
        begin
            m = AddressBits'(a);
            s = '0;
            if (IdxBits > 0) begin
                s = IdxW'(m >> OffBits);
            end
            if ((1 << IdxBits) != NumSets && int'(s) >= NumSets) begin
                s = IdxW'(int'(s) - NumSets);
            end
            return s;
        end
    endfunction

    function automatic tag_t addr_tag(input logic [23:0] a);
        logic [AddressBits-1:0] m;
        begin
            m = AddressBits'(a);
            if (TagBits == 0) begin
                return '0;
            end
            return TagW'(m >> (OffBits + IdxBits));
        end
    endfunction

    function automatic rank_row_t reset_ranks();
        rank_row_t r;
        begin
            for (int w = 0; w < Ways; w++) begin
                r[w] = RankW'(w);
            end
            return r;
        end
    endfunction

endpackage

### src/set_assoc_lru_cache_tag_controller_top.sv
// Top level of the set-associative LRU cache tag controller.
//   Channel  Direction  Payload
//   s_       in         command, address
//   m_       out        hit, hit_way, memory_read, memory_write
//   cfg_     in         write_through_mode
// The back end handles one access at a time: set read, lookup and update, result.
// A two-entry queue lets the front accept accesses while the back works or stalls.
// After reset a clearing pass, one set a cycle over all 128 sets, runs before the back end takes accesses.
// Configuration writes are always taken.
module set_assoc_lru_cache_tag_controller_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  salru_pkg::salru_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output salru_pkg::salru_out_t m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);
    import salru_pkg::*;

    logic       wt_reg;
    logic       q_valid, q_ready;
    salru_req_t q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wt_reg <= 1'b0;
        end else if (cfg_valid) begin
            wt_reg <= cfg_data;
        end
    end

    salru_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_valid, .q_ready, .q_data
    );

    salru_back u_back (
        .aclk, .aresetn, .write_through(wt_reg),
        .q_valid, .q_ready, .q_data,
        .m_valid, .m_ready, .m_data
    );

endmodule

### src/salru_front.sv
// Front end: accepts accesses, splits the address and queues the request.
module salru_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  salru_pkg::salru_in_t  s_data,
    output logic                  q_valid,
    input  logic                  q_ready,
    output salru_pkg::salru_req_t q_data
);
    import salru_pkg::*;

    localparam int Depth = 2;

    salru_req_t  fifo_reg [Depth];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;
    salru_req_t  req;

    assign req.is_write = (s_data.command == CMD_WRITE);
    assign req.set      = addr_set(s_data.address);
    assign req.tag      = addr_tag(s_data.address);

    assign s_ready = (count_reg != 2'(Depth));
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = fifo_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            fifo_reg[wr_ptr_reg] <= req;
        end
    end

endmodule

### src/salru_back.sv
// Back end: tag lookup, replacement, state update and the result register.
module salru_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  write_through,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  salru_pkg::salru_req_t q_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output salru_pkg::salru_out_t m_data
);
    import salru_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_OUT
    } state_t;

    state_t     state_reg;
    set_t       clr_reg;
    salru_req_t req_reg;
    salru_out_t out_reg;

    tag_row_t   tag_mem [NumSets];
    logic [Ways-1:0] valid_mem [NumSets];
    logic [Ways-1:0] dirty_mem [NumSets];
    rank_row_t  rank_mem [NumSets];

    tag_row_t        tag_rd_reg;
    logic [Ways-1:0] valid_rd_reg;
    logic [Ways-1:0] dirty_rd_reg;
    rank_row_t       rank_rd_reg;

    logic            hit;
    logic [WayW-1:0] way;
    logic            mem_rd, mem_wr;
    logic [Ways-1:0] dirty_new;
    logic [Ways-1:0] valid_new;
    rank_row_t       rank_new;
    tag_row_t        tag_new;

    assign q_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = out_reg;

    always_comb begin
        logic            found;
        logic [RankW-1:0] best;
        logic [RankW-1:0] old;
        hit = 1'b0;
        way = '0;
        found = 1'b0;
        best = '0;
        mem_rd = 1'b0;
        mem_wr = 1'b0;
        dirty_new = dirty_rd_reg;
        valid_new = valid_rd_reg;
        tag_new = tag_rd_reg;
        for (int w = Ways - 1; w >= 0; w--) begin
            if (valid_rd_reg[w] && tag_rd_reg[w] == req_reg.tag) begin
                hit = 1'b1;
                way = WayW'(w);
            end
        end
        if (hit) begin
            if (req_reg.is_write) begin
                if (write_through) begin
                    mem_wr = 1'b1;
                end else begin
                    dirty_new[way] = 1'b1;
                end
            end
        end else begin
            for (int w = Ways - 1; w >= 0; w--) begin
                if (!valid_rd_reg[w]) begin
                    found = 1'b1;
                    way = WayW'(w);
                end
            end
            if (!found) begin
                for (int w = 0; w < Ways; w++) begin
                    if (rank_rd_reg[w] >= best) begin
                        best = rank_rd_reg[w];
                        way = WayW'(w);
                    end
                end
            end
            if (valid_rd_reg[way] && dirty_rd_reg[way]) begin
                mem_wr = 1'b1;
            end
            if (req_reg.is_write && write_through) begin
                mem_wr = 1'b1;
                dirty_new[way] = 1'b0;
            end else begin
                mem_rd = 1'b1;
                dirty_new[way] = req_reg.is_write;
            end
            valid_new[way] = 1'b1;
            tag_new[way] = req_reg.tag;
        end
        old = rank_rd_reg[way];
        rank_new = rank_rd_reg;
        for (int w = 0; w < Ways; w++) begin
            if (rank_rd_reg[w] < old) begin
                rank_new[w] = rank_rd_reg[w] + 1'b1;
            end
        end
        rank_new[way] = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    valid_mem[clr_reg] <= '0;
                    dirty_mem[clr_reg] <= '0;
                    rank_mem[clr_reg]  <= reset_ranks();
                    if (int'(clr_reg) == NumSets - 1) begin
                        state_reg <= ST_IDLE;
                    end
                    clr_reg <= clr_reg + 1'b1;
                end
                ST_IDLE: begin
                    if (q_valid) begin
                        req_reg      <= q_data;
                        tag_rd_reg   <= tag_mem[q_data.set];
                        valid_rd_reg <= valid_mem[q_data.set];
                        dirty_rd_reg <= dirty_mem[q_data.set];
                        rank_rd_reg  <= rank_mem[q_data.set];
                        state_reg    <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP: begin
                    tag_mem[req_reg.set]   <= tag_new;
                    valid_mem[req_reg.set] <= valid_new;
                    dirty_mem[req_reg.set] <= dirty_new;
                    rank_mem[req_reg.set]  <= rank_new;
                    out_reg.hit          <= hit;
                    out_reg.hit_way      <= 2'(way);
                    out_reg.memory_read  <= mem_rd;
                    out_reg.memory_write <= mem_wr;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### src/salru_checker.sv
// Port-level checker for the cache tag controller, bound to the top level.
module salru_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input salru_pkg::salru_out_t m_data
);
    import salru_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_hit_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.hit |-> !m_data.memory_read)
        else $error("hit fetched from memory");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result during reset");

    a_no_out_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_valid)
        else $error("result right after reset");

endmodule

bind set_assoc_lru_cache_tag_controller_top salru_checker u_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_data
);

### tb/sv/tb.sv
// Testbench for the cache tag controller, checked against a behavioral cache model.
`timescale 1ns / 100ps

module tb;
    import salru_pkg::*;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 40;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    salru_in_t  s_data;
    logic       m_valid;
    logic       m_ready;
    salru_out_t m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;

    set_assoc_lru_cache_tag_controller_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    logic [TagW-1:0] line_tag [NumSets][Ways];
    logic            line_valid [NumSets][Ways];
    logic            line_dirty [NumSets][Ways];
    int              line_rank [NumSets][Ways];
    logic            wt_mode;

    salru_in_t  access_queue[$];
    salru_out_t expected_results[$];
    int         error_count;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_off_cycles;
    int         stall_cycles;
    int         hits_seen;
    int         writebacks_seen;
    int         results_seen;

    function automatic salru_out_t cache_access(input salru_in_t acc);
        salru_out_t r;
        int set_no;
        logic [TagW-1:0] tg;
        int way;
        int best;
        logic found;
        logic is_wr;
        begin
            set_no = int'(acc.address[OffBits +: IdxBits]) % NumSets;
            tg = acc.address[23 -: TagBits];
            is_wr = (acc.command == CMD_WRITE);
            r = '0;
            way = 0;
            for (int w = Ways - 1; w >= 0; w--) begin
                if (line_valid[set_no][w] && line_tag[set_no][w] == tg) begin
                    r.hit = 1'b1;
                    way = w;
                end
            end
            if (r.hit) begin
                if (is_wr) begin
                    if (wt_mode) r.memory_write = 1'b1;
                    else line_dirty[set_no][way] = 1'b1;
                end
            end else begin
                found = 1'b0;
                for (int w = Ways - 1; w >= 0; w--) begin
                    if (!line_valid[set_no][w]) begin
                        way = w;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    best = 0;
                    for (int w = 0; w < Ways; w++) begin
                        if (line_rank[set_no][w] >= best) begin
                            best = line_rank[set_no][w];
                            way = w;
                        end
                    end
                end
                if (line_valid[set_no][way] && line_dirty[set_no][way]) r.memory_write = 1'b1;
                if (is_wr && wt_mode) begin
                    r.memory_write = 1'b1;
                    line_dirty[set_no][way] = 1'b0;
                end else begin
                    r.memory_read = 1'b1;
                    line_dirty[set_no][way] = is_wr;
                end
                line_valid[set_no][way] = 1'b1;
                line_tag[set_no][way] = tg;
            end
            best = line_rank[set_no][way];
            for (int w = 0; w < Ways; w++) begin
                if (line_rank[set_no][w] < best) line_rank[set_no][w]++;
            end
            line_rank[set_no][way] = 0;
            r.hit_way = 2'(way);
            return r;
        end
    endfunction

    function automatic salru_in_t make_access(input logic cmd, input int set_no,
                                              input int tg, input int off);
        salru_in_t a;
        begin
            a.command = cmd;
            a.address = {TagBits'(tg), IdxBits'(set_no), OffBits'(off)};
            return a;
        end
    endfunction

    task automatic write_mode(input logic mode);
        begin
            @(posedge aclk);
            cfg_valid <= 1'b1;
            cfg_data  <= mode;
            do @(posedge aclk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            wt_mode = mode;
        end
    endtask

    task automatic wait_drained();
        begin
            while (access_queue.size() != 0 || s_valid || expected_results.size() != 0)
                @(posedge aclk);
            repeat (DrainCycles) @(posedge aclk);
        end
    endtask

    task automatic add_random(input int count);
        int set_no;
        begin
            for (int i = 0; i < count; i++) begin
                if ($urandom_range(0, 9) < 8) begin
                    set_no = $urandom_range(0, 3);
                    access_queue.push_back(make_access(1'($urandom), set_no,
                        $urandom_range(0, 6), $urandom_range(0, BlockBytes - 1)));
                end else begin
                    access_queue.push_back({1'($urandom), 24'($urandom)});
                end
            end
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid && s_ready) expected_results.push_back(cache_access(s_data));
            if (access_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= access_queue.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_data.hit) hits_seen++;
                if (m_data.memory_write) writebacks_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_data);
                    error_count++;
                end else if (expected_results[0] !== m_data) begin
                    $display("%0t: expected %h actual %h", $time,
                             expected_results[0], m_data);
                    error_count++;
                    void'(expected_results.pop_front());
                end else begin
                    void'(expected_results.pop_front());
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WatchdogLimit) begin
                $display("[set_assoc_lru_cache_tag_controller_top] ERROR");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        error_count = 0;
        hold_off_cycles = 0;
        results_seen = 0;
        hits_seen = 0;
        writebacks_seen = 0;
        send_idle_pct = 29;
        recv_idle_pct = 78;
        wt_mode = 1'b0;
        for (int s = 0; s < NumSets; s++) begin
            for (int w = 0; w < Ways; w++) begin
                line_tag[s][w] = '0;
                line_valid[s][w] = 1'b0;
                line_dirty[s][w] = 1'b0;
                line_rank[s][w] = w;
            end
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        write_mode(1'b0);
        access_queue.push_back({CMD_READ, 24'h000000});
        access_queue.push_back({CMD_WRITE, 24'hFFFFFF});
        access_queue.push_back({CMD_READ, 24'hFFFFFF});
        access_queue.push_back({CMD_WRITE, 24'h000000});
        for (int t = 1; t <= 5; t++) access_queue.push_back(make_access(CMD_WRITE, 5, t, t));
        for (int t = 1; t <= 5; t++) access_queue.push_back(make_access(CMD_READ, 5, t, 31));
        access_queue.push_back({CMD_READ, 24'hAAAAAA});
        access_queue.push_back({CMD_WRITE, 24'h555555});
        hold_off_cycles = 300;
        add_random(140);
        wait_drained();

        write_mode(1'b1);
        send_idle_pct = 78;
        recv_idle_pct = 29;
        for (int t = 1; t <= 5; t++) access_queue.push_back(make_access(CMD_WRITE, 5, t, 0));
        access_queue.push_back(make_access(CMD_READ, 5, 9, 0));
        add_random(140);
        wait_drained();

        write_mode(1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(80);
        wait_drained();
        write_mode(1'b1);
        add_random(60);
        wait_drained();

        $display("Covered %0d accesses in both write modes: %0d hits, %0d memory writes.",
                 results_seen, hits_seen, writebacks_seen);
        if (error_count == 0) begin
            $display("[set_assoc_lru_cache_tag_controller_top] OK");
        end else begin
            $display("[set_assoc_lru_cache_tag_controller_top] ERROR");
        end
        $finish;
    end
endmodule
